@@ rtl/madc_pkg.sv @@
// Shared constants, request codes and read-out scaling for the multichannel ADC averager.
// No dependencies; used by rtl/multichannel_adc_average_change_scale.sv.
package madc_pkg;

    localparam int unsigned WINDOW_DEFAULT = 8;
    localparam int unsigned PORTS_DEFAULT  = 16;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned PORT_W   = 4;
    localparam int unsigned SCALED_W = 11;
    localparam int unsigned MAX_PORTS = 2 ** PORT_W;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd4;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        FMT_BYTE_FADER  = 2'd0,
        FMT_BYTE_VOLUME = 2'd1,
        FMT_WORD_FADER  = 2'd2,
        FMT_WORD_VOLUME = 2'd3
    } format_t;

    // ceil(2^20 / 125): floor(a * 8389 >> 20) == floor(a / 125) for all 10-bit a
    localparam logic [13:0] INV125 = 14'd8389;

    // x * 1.008 == x + x/125, so the fader gain is an add of a small quotient
    function automatic logic [SCALED_W-1:0] scale_value(
        input logic [SAMPLE_W-1:0] avg,
        input format_t             fmt
    );
        logic [6:0]          x;
        logic [7:0]          bf;
        logic [6:0]          bv;
        logic [23:0]         prod;
        logic [3:0]          q;
        logic [SCALED_W-1:0] wf;
        logic [SCALED_W-1:0] wv;
        logic [SCALED_W-1:0] v;
        x    = avg[SAMPLE_W-1:3];
        bf   = {1'b0, x} + ((x >= 7'd125) ? 8'd1 : 8'd0);
        bv   = 7'd127 - x;
        prod = {14'd0, avg} * {10'd0, INV125};
        q    = prod[23:20];
        wf   = {1'b0, avg} + {7'd0, q};
        wv   = 11'd1024 - {1'b0, avg};
        unique case (fmt)
            FMT_BYTE_FADER: begin
                if (bf < 8'd2) v = '0;
                else if (bf > 8'd127) v = 11'd127;
                else v = {3'd0, bf};
            end
            FMT_BYTE_VOLUME: begin
                if (bv >= 7'd61 && bv <= 7'd65) v = 11'd63;
                else v = {4'd0, bv};
            end
            FMT_WORD_FADER: begin
                if (wf < 11'd8) v = '0;
                else if (wf > 11'd1024) v = 11'd1024;
                else v = wf;
            end
            FMT_WORD_VOLUME: begin
                if (wv >= 11'd507 && wv <= 11'd517) v = 11'd512;
                else v = wv;
            end
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/multichannel_adc_average_change_scale.sv @@
// Top level: per-port block averager with change detection and scaled read-out.
// Depends on rtl/madc_pkg.sv.
// From s_ valid/ready to m_valid: input register, then result register.
// One request per cycle unless m_ready stalls; per-port state is read and rewritten in the
// same cycle between the two registers, so back-to-back requests to a port see its updates.
// Reset (aresetn low, synchronous): all per-port sums, counts, averages, last reported
// values and send flags go to zero, the change threshold to 4, both valids low.
module multichannel_adc_average_change_scale #(
    parameter int unsigned WINDOW = madc_pkg::WINDOW_DEFAULT,
    parameter int unsigned PORTS  = madc_pkg::PORTS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [madc_pkg::SAMPLE_W-1:0]      cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic [madc_pkg::PORT_W-1:0]        s_port,
    input  logic [madc_pkg::SAMPLE_W-1:0]      s_sample,
    input  logic [1:0]                         s_format,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [madc_pkg::SAMPLE_W-1:0]      m_average,
    output logic [madc_pkg::SCALED_W-1:0]      m_scaled,
    output logic                               m_send_flag,
    output logic                               m_window_done
);

    // only 16 ports are addressable by the port field
    localparam int unsigned NUM_PORTS = (PORTS < madc_pkg::MAX_PORTS) ? PORTS
                                                                     : madc_pkg::MAX_PORTS;
    localparam int unsigned IDX_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int unsigned CNT_W  = $clog2(WINDOW);
    localparam int unsigned SUM_W  = madc_pkg::SAMPLE_W + CNT_W;
    // reciprocal multiply: exact floor(sum / WINDOW) for every SUM_W-bit sum
    localparam int unsigned SHIFT  = SUM_W + CNT_W;
    localparam int unsigned RECIP_W = SUM_W + 1;
    localparam int unsigned PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + WINDOW - 1) / WINDOW);
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(WINDOW - 1);
    localparam logic [madc_pkg::PORT_W:0] PORT_LIMIT = (madc_pkg::PORT_W + 1)'(NUM_PORTS);

    localparam int unsigned AVG_W = madc_pkg::SAMPLE_W;

    // per-port state
    logic [SUM_W-1:0] sum_reg  [NUM_PORTS];
    logic [CNT_W-1:0] cnt_reg  [NUM_PORTS];
    logic [AVG_W-1:0] avg_reg  [NUM_PORTS];
    logic [AVG_W-1:0] last_reg [NUM_PORTS];
    logic             flag_reg [NUM_PORTS];

    logic [AVG_W-1:0] threshold_reg;

    // input register
    logic                         in_valid_reg;
    madc_pkg::action_t            action_reg;
    logic [madc_pkg::PORT_W-1:0]  port_reg;
    logic [AVG_W-1:0]             sample_reg;
    madc_pkg::format_t            format_reg;

    logic advance;
    logic port_ok;
    logic [IDX_W-1:0] idx;

    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [AVG_W-1:0]  avg_next;
    logic [AVG_W-1:0]  last_next;
    logic              flag_next;
    logic              done_next;
    logic [SUM_W-1:0]  acc;
    logic [PROD_W-1:0] prod;
    logic [AVG_W-1:0]  block_avg;
    logic [AVG_W-1:0]  diff;
    logic [madc_pkg::SCALED_W-1:0] scaled_next;

    assign advance = !m_valid || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign port_ok = {1'b0, port_reg} < PORT_LIMIT;
    assign idx     = port_reg[IDX_W-1:0];

    assign acc       = sum_reg[idx] + SUM_W'(sample_reg);
    assign prod      = {{RECIP_W{1'b0}}, acc} * {{SUM_W{1'b0}}, RECIP};
    assign block_avg = prod[SHIFT +: AVG_W];
    assign diff      = (block_avg > last_reg[idx]) ? (block_avg - last_reg[idx])
                                                   : (last_reg[idx] - block_avg);

    always_comb begin
        sum_next    = sum_reg[idx];
        cnt_next    = cnt_reg[idx];
        avg_next    = avg_reg[idx];
        last_next   = last_reg[idx];
        flag_next   = flag_reg[idx];
        done_next   = 1'b0;
        scaled_next = '0;
        unique case (action_reg)
            madc_pkg::ACT_SAMPLE: begin
                if (cnt_reg[idx] >= LAST_CNT) begin
                    sum_next  = '0;
                    cnt_next  = '0;
                    avg_next  = block_avg;
                    done_next = 1'b1;
                    if (diff > threshold_reg) begin
                        last_next = block_avg;
                        flag_next = 1'b1;
                    end
                end else begin
                    sum_next = acc;
                    cnt_next = cnt_reg[idx] + CNT_W'(1);
                end
            end
            madc_pkg::ACT_READ: begin
                scaled_next = madc_pkg::scale_value(avg_reg[idx], format_reg);
            end
            madc_pkg::ACT_CLEAR: begin
                flag_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= madc_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            action_reg <= madc_pkg::action_t'(s_action);
            port_reg   <= s_port;
            sample_reg <= s_sample;
            format_reg <= madc_pkg::format_t'(s_format);
        end
    end

    // per-port state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                sum_reg[p]  <= '0;
                cnt_reg[p]  <= '0;
                avg_reg[p]  <= '0;
                last_reg[p] <= '0;
                flag_reg[p] <= 1'b0;
            end
        end else if (in_valid_reg && advance && port_ok) begin
            sum_reg[idx]  <= sum_next;
            cnt_reg[idx]  <= cnt_next;
            avg_reg[idx]  <= avg_next;
            last_reg[idx] <= last_next;
            flag_reg[idx] <= flag_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            if (port_ok) begin
                m_average     <= avg_next;
                m_scaled      <= scaled_next;
                m_send_flag   <= flag_next;
                m_window_done <= done_next;
            end else begin
                m_average     <= '0;
                m_scaled      <= '0;
                m_send_flag   <= 1'b0;
                m_window_done <= 1'b0;
            end
        end
    end

endmodule
